// ===== rtl/rmtf_pkg.sv =====
// Package for the range move-to-front line: payload structs, cell control,
// scan state enum and fixed field widths.
// No dependencies.
`default_nettype none

package rmtf_pkg;

	localparam int POS_W  = 6;
	localparam int ELEM_W = 7;
	localparam int CNT_W  = 7;

	localparam logic OP_MOVE = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} scan_state_t;

	typedef struct packed {
		logic             op;
		logic [POS_W-1:0] span_start;
		logic [POS_W-1:0] span_end;
		logic [POS_W-1:0] read_position;
	} cmd_t;

	typedef struct packed {
		logic [ELEM_W-1:0] element_number;
		logic              error;
	} rsp_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		logic             restore;
		logic             move;
		logic             load;
		logic             shift;
		logic [POS_W-1:0] lo;
		logic [POS_W-1:0] hi;
		logic [POS_W-1:0] len;
		logic [POS_W-1:0] rp;
		logic [CNT_W-1:0] count;
	} cell_ctrl_t;

	typedef struct packed {
		logic busy;
		logic shift;
		logic finish;
	} scan_stat_t;

endpackage

`default_nettype wire

// ===== rtl/range_move_to_front_list_top.sv =====
// Top level of the range move-to-front line: command decode, count register,
// result register, cell chain and scan sequencer. Uses rmtf_pkg, rmtf_cell,
// rmtf_ctrl.
//
//   channel   handshake                 payload
//   command   start & !busy             cmd (rmtf_pkg::cmd_t)
//   result    done, one-cycle strobe    rsp (rmtf_pkg::rsp_t)
//   config    cfg_we                    cfg_wdata (entry_count)
//
// A move, or any rejected command, leaves busy low; its result strobes on the
// next cycle and the next command can enter right after acceptance.
// A good read raises busy: the match walks the cell chain one cell per cycle,
// and busy stays high until the result strobes.
// Reset gives entry_count = 64 (saturated to MAX_ENTRIES) and identity order;
// a config write restores identity order as well.
// The receiver cannot stall: done lasts exactly one cycle.
`default_nettype none

module range_move_to_front_list_top #(
	parameter int MAX_ENTRIES = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire rmtf_pkg::cmd_t                cmd,
	output logic                               done,
	output rmtf_pkg::rsp_t                     rsp,
	input  wire logic                          cfg_we,
	input  wire logic [rmtf_pkg::CNT_W-1:0]    cfg_wdata
);

	localparam logic [rmtf_pkg::CNT_W-1:0] MAX_N = rmtf_pkg::CNT_W'(MAX_ENTRIES);
	localparam logic [rmtf_pkg::CNT_W-1:0] RST_N = (MAX_ENTRIES < 64) ? MAX_N : 7'd64;

	logic [rmtf_pkg::CNT_W-1:0] count_q;
	logic                       accept;
	logic                       move_err;
	logic                       read_err;
	logic                       is_read;
	rmtf_pkg::cell_ctrl_t       ctrl;
	rmtf_pkg::scan_stat_t       stat;
	logic [rmtf_pkg::ELEM_W-1:0] res [MAX_ENTRIES];
	logic                       done_q;
	rmtf_pkg::rsp_t             rsp_q;

	assign accept   = start && !stat.busy;
	assign is_read  = (cmd.op == rmtf_pkg::OP_READ);
	assign move_err = (cmd.span_start > cmd.span_end)
	                  || ({1'b0, cmd.span_end} >= count_q);
	assign read_err = ({1'b0, cmd.read_position} >= count_q);

	always_comb begin
		ctrl         = '0;
		ctrl.restore = cfg_we;
		ctrl.move    = accept && !is_read && !move_err;
		ctrl.load    = accept && is_read && !read_err;
		ctrl.shift   = stat.shift;
		ctrl.lo      = cmd.span_start;
		ctrl.hi      = cmd.span_end;
		ctrl.len     = cmd.span_end - cmd.span_start + 1'b1;
		ctrl.rp      = cmd.read_position;
		ctrl.count   = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= RST_N;
		end else if (cfg_we) begin
			count_q <= (cfg_wdata > MAX_N) ? MAX_N : cfg_wdata;
		end
	end

	rmtf_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (ctrl.load),
		.stat   (stat)
	);

	for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
		if (k == 0) begin : g_head
			rmtf_cell #(.IDX(k)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.res_prev ('0),
				.res_q    (res[k])
			);
		end else begin : g_body
			rmtf_cell #(.IDX(k)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.res_prev (res[k-1]),
				.res_q    (res[k])
			);
		end
	end

	// Immediate result for moves and rejected commands; scan result at finish.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && !ctrl.load) || stat.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.finish) begin
			rsp_q.element_number <= res[MAX_ENTRIES-1];
			rsp_q.error          <= 1'b0;
		end else if (accept) begin
			rsp_q.element_number <= '0;
			rsp_q.error          <= is_read ? read_err : move_err;
		end
	end

	assign busy = stat.busy;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/rmtf_cell.sv =====
// One cell of the line: holds the position of one element, updates it on a
// move, and passes read-match results down the chain. Uses rmtf_pkg.
`default_nettype none

module rmtf_cell #(
	parameter int IDX = 0
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rmtf_pkg::cell_ctrl_t          ctrl,
	input  wire logic [rmtf_pkg::ELEM_W-1:0]   res_prev,
	output logic      [rmtf_pkg::ELEM_W-1:0]   res_q
);

	localparam logic [rmtf_pkg::POS_W-1:0]  HOME  = rmtf_pkg::POS_W'(IDX);
	localparam logic [rmtf_pkg::CNT_W-1:0]  IDX_N = rmtf_pkg::CNT_W'(IDX);
	localparam logic [rmtf_pkg::ELEM_W-1:0] ELEM  = rmtf_pkg::ELEM_W'(IDX + 1);

	logic [rmtf_pkg::POS_W-1:0] pos_q;
	logic                       active;
	logic                       in_span;
	logic                       before_span;

	assign active      = IDX_N < ctrl.count;
	assign in_span     = pos_q inside {[ctrl.lo:ctrl.hi]};
	assign before_span = pos_q < ctrl.lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= HOME;
		end else if (ctrl.restore) begin
			pos_q <= HOME;
		end else if (ctrl.move && active) begin
			if (in_span) begin
				pos_q <= pos_q - ctrl.lo;
			end else if (before_span) begin
				pos_q <= pos_q + ctrl.len;
			end
		end
	end

	// Exactly one live cell matches, so OR-ing down the chain collects it.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			res_q <= (active && pos_q == ctrl.rp) ? ELEM : '0;
		end else if (ctrl.shift) begin
			res_q <= res_q | res_prev;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rmtf_ctrl.sv =====
// Read-scan sequencer: idle/scan state machine and shift counter that walks
// match results to the end of the cell chain. Uses rmtf_pkg.
`default_nettype none

module rmtf_ctrl #(
	parameter int MAX_ENTRIES = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	output rmtf_pkg::scan_stat_t      stat
);

	localparam int SC_W = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
	localparam logic [SC_W-1:0] LAST = SC_W'(MAX_ENTRIES - 1);

	rmtf_pkg::scan_state_t state_q;
	rmtf_pkg::scan_state_t state_nxt;
	logic [SC_W-1:0]       cnt_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rmtf_pkg::ST_IDLE: begin
				if (load) state_nxt = rmtf_pkg::ST_SCAN;
			end
			rmtf_pkg::ST_SCAN: begin
				if (cnt_q == LAST) state_nxt = rmtf_pkg::ST_IDLE;
			end
			default: state_nxt = rmtf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		stat = '0;
		case (state_q)
			rmtf_pkg::ST_SCAN: begin
				stat.busy   = 1'b1;
				stat.finish = (cnt_q == LAST);
				stat.shift  = (cnt_q != LAST);
			end
			default: stat = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmtf_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (load) begin
				cnt_q <= '0;
			end else if (stat.shift) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire
